@@ rtl/core/prc_pkg.sv @@
// Package for the pinned reference-count key table.
// Holds the beat structs, operation and status codes, and the cell types.
// No dependencies.
package prc_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_DELETE = 2'd2,
        OP_PURGE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PINNED    = 2'd3
    } status_t;

    localparam logic [31:0] REFS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        op_t         operation;
        logic [31:0] file_key;
        logic [31:0] fragment_key;
        logic        pin_flag;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] ref_count;
        logic [6:0]  entries_used;
    } rsp_t;

    typedef struct packed {
        logic [31:0] file;
        logic [31:0] fragment;
        logic [31:0] refs;
        logic        pinned;
    } entry_t;

    // LOAD_LEFT moves entries toward the back, LOAD_RIGHT toward the front
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD_LEFT  = 2'd1,
        CELL_LOAD_RIGHT = 2'd2,
        CELL_INC        = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      capture;
    } cell_ctl_t;

endpackage

@@ rtl/core/pinned_refcount_key_table_top.sv @@
// Top level of the pinned reference-count key table: cell chain and sequencer.
// Depends on prc_pkg and prc_cell.
//
//   channel | signals                   | direction | payload
//   req     | req_valid, req_ready, req | in        | req_t: operation, keys, pin_flag
//   rsp     | rsp_valid, rsp_ready, rsp | out       | rsp_t: status, ref_count, entries_used
//
// For insert, touch and delete, the accept cycle latches every cell's key compare;
// S_EXEC then shifts or updates the chain and loads the result once the output is free.
// Purge removes unpinned entries front first, one removal per cycle while the output is free.
// Reset clears the valid bits and the entry count; no clearing pass.
// A result waiting on rsp_ready holds the chain and the sequencer in place.
module pinned_refcount_key_table_top
    import prc_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t          state_reg;
    req_t            req_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    rsp_t            rsp_reg;
    rsp_t            rsp_next;
    logic            rsp_valid_reg;
    logic            done;

    entry_t          ent [ENTRIES];
    logic [31:0]     inc_refs [ENTRIES];
    cell_ctl_t       ctl [ENTRIES];
    cell_cmd_t       cmd [ENTRIES];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] pin_vec;
    logic [ENTRIES-1:0] m_first;
    logic [ENTRIES-1:0] m_ge;
    logic [ENTRIES-1:0] unp;
    logic [ENTRIES-1:0] unp_ge;
    logic            accept;
    logic            out_free;
    logic            any_hit;
    logic            hit_pinned;
    logic            full;
    logic [31:0]     refs_sel;
    logic [CW+6:0]   used_ext;
    entry_t          new_entry;

    assign accept   = req_valid && (state_reg == S_IDLE);
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign new_entry = '{file: req_reg.file_key, fragment: req_reg.fragment_key,
                         refs: 32'd0, pinned: req_reg.pin_flag};

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            entry_t lent;
            logic   lval;
            entry_t rent;
            logic   rval;
            logic   v;
            logic   mt;

            if (g == 0)
            begin : g_head
                assign lent = new_entry;
                assign lval = 1'b1;
            end
            else
            begin : g_mid
                assign lent = ent[g-1];
                assign lval = valid_vec[g-1];
            end

            if (g == ENTRIES - 1)
            begin : g_tail
                assign rent = '0;
                assign rval = 1'b0;
            end
            else
            begin : g_body
                assign rent = ent[g+1];
                assign rval = valid_vec[g+1];
            end

            assign ctl[g] = '{cmd: cmd[g], capture: accept};

            prc_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl[g]),
                .key_file     (req.file_key),
                .key_fragment (req.fragment_key),
                .left_entry   (lent),
                .left_valid   (lval),
                .right_entry  (rent),
                .right_valid  (rval),
                .entry        (ent[g]),
                .valid        (v),
                .match        (mt),
                .refs_inc     (inc_refs[g])
            );

            assign valid_vec[g] = v;
            assign match_vec[g] = mt;
            assign pin_vec[g]   = ent[g].pinned;
        end
    endgenerate

    // lowest set bit, and the mask of that bit and everything behind it
    assign m_first    = match_vec & (~match_vec + 1'b1);
    assign m_ge       = match_vec | (~match_vec + 1'b1);
    assign unp        = valid_vec & ~pin_vec;
    assign unp_ge     = unp | (~unp + 1'b1);
    assign any_hit    = |match_vec;
    assign hit_pinned = |(m_first & pin_vec);
    assign full       = (count_reg == CW'(ENTRIES));

    always_comb
    begin
        refs_sel = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            refs_sel = refs_sel | (inc_refs[i] & {32{m_first[i]}});
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cmd[i] = CELL_HOLD;
        end
        count_next = count_reg;
        done       = 1'b0;
        rsp_next   = '{status: ST_DONE, ref_count: 32'd0, entries_used: 7'd0};

        if (state_reg == S_EXEC && out_free)
        begin
            case (req_reg.operation)
                OP_INSERT:
                begin
                    done = 1'b1;
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            cmd[i] = CELL_LOAD_LEFT;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_TOUCH:
                begin
                    done = 1'b1;
                    if (!any_hit)
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (m_first[i])
                            begin
                                cmd[i] = CELL_INC;
                            end
                        end
                        rsp_next.ref_count = refs_sel;
                    end
                end
                OP_DELETE:
                begin
                    done = 1'b1;
                    if (!any_hit)
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                    else if (hit_pinned)
                    begin
                        rsp_next.status = ST_PINNED;
                    end
                    else
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (m_ge[i])
                            begin
                                cmd[i] = CELL_LOAD_RIGHT;
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_PURGE:
                begin
                    // drop the frontmost unpinned entry each cycle while the output is free, until none is left
                    if (|unp)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (unp_ge[i])
                            begin
                                cmd[i] = CELL_LOAD_RIGHT;
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end

        used_ext = {7'd0, count_next};
        rsp_next.entries_used = used_ext[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count disagrees with valid cells");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("valid cells not packed at the front");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp_next.status == ST_FULL) |=> (int'(count_reg) == ENTRIES))
        else $error("full reported on a table with room");
`endif

endmodule

@@ rtl/core/prc_cell.sv @@
// One slot of the key table chain: entry storage, key compare, count increment.
// Depends on prc_pkg.
module prc_cell
    import prc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctl_t   ctl,
    input  logic [31:0] key_file,
    input  logic [31:0] key_fragment,
    input  entry_t      left_entry,
    input  logic        left_valid,
    input  entry_t      right_entry,
    input  logic        right_valid,
    output entry_t      entry,
    output logic        valid,
    output logic        match,
    output logic [31:0] refs_inc
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;
    logic   match_reg;

    // saturate at the top of the count range
    assign refs_inc = (entry_reg.refs == REFS_MAX) ? entry_reg.refs : entry_reg.refs + 32'd1;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (ctl.cmd)
            CELL_LOAD_LEFT:
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
            CELL_LOAD_RIGHT:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            CELL_INC:
            begin
                entry_next.refs = refs_inc;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.capture)
            begin
                match_reg <= valid_reg && (entry_reg.file == key_file)
                             && (entry_reg.fragment == key_fragment);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

@@ dv/prc_tb_pkg.sv @@
// Scoreboard for the pinned reference-count key table testbench.
// Keeps its own ordered copy of the table and a queue of expected response beats.
// Depends on prc_pkg.
package prc_tb_pkg;
    import prc_pkg::*;

    class table_scoreboard;
        int      capacity;
        entry_t  rows[$];          // front of the queue is the frontmost entry
        rsp_t    expected_q[$];
        int      accepted;
        int      checked;
        int      mismatches;
        int      op_seen[4];
        int      status_seen[4];

        function new(int depth);
            capacity = depth;
            accepted = 0;
            checked = 0;
            mismatches = 0;
            foreach (op_seen[i])
            begin
                op_seen[i] = 0;
                status_seen[i] = 0;
            end
        endfunction

        function int find_front(logic [31:0] fk, logic [31:0] gk);
            foreach (rows[i])
            begin
                if (rows[i].file == fk && rows[i].fragment == gk)
                    return i;
            end
            return -1;
        endfunction

        function entry_t any_row();
            return rows[$urandom_range(rows.size() - 1)];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted request beat to the shadow table and queue its response.
        function void note_request(req_t r);
            rsp_t   e;
            entry_t fresh;
            entry_t kept[$];
            int     hit;
            e = '0;
            e.status = ST_DONE;
            case (r.operation)
                OP_INSERT:
                begin
                    if (rows.size() >= capacity)
                        e.status = ST_FULL;
                    else
                    begin
                        fresh.file = r.file_key;
                        fresh.fragment = r.fragment_key;
                        fresh.refs = '0;
                        fresh.pinned = r.pin_flag;
                        rows.push_front(fresh);
                    end
                end
                OP_TOUCH:
                begin
                    hit = find_front(r.file_key, r.fragment_key);
                    if (hit < 0)
                        e.status = ST_NOT_FOUND;
                    else
                    begin
                        if (rows[hit].refs != REFS_MAX)
                            rows[hit].refs = rows[hit].refs + 32'd1;
                        e.ref_count = rows[hit].refs;
                    end
                end
                OP_DELETE:
                begin
                    hit = find_front(r.file_key, r.fragment_key);
                    if (hit < 0)
                        e.status = ST_NOT_FOUND;
                    else if (rows[hit].pinned)
                        e.status = ST_PINNED;
                    else
                        rows.delete(hit);
                end
                default:
                begin
                    // keep pinned entries in their relative order
                    foreach (rows[i])
                    begin
                        if (rows[i].pinned)
                            kept.push_back(rows[i]);
                    end
                    rows = kept;
                end
            endcase
            e.entries_used = 7'(rows.size());
            op_seen[r.operation]++;
            status_seen[e.status]++;
            accepted++;
            expected_q.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: response beat with nothing expected: status %0d refs %0d used %0d",
                         $time, got.status, got.ref_count, got.entries_used);
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
            begin
                mismatches++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, e.status, got.status);
            end
            if (got.ref_count !== e.ref_count)
            begin
                mismatches++;
                $display("%0t: ref_count mismatch, expected %0d, actual %0d",
                         $time, e.ref_count, got.ref_count);
            end
            if (got.entries_used !== e.entries_used)
            begin
                mismatches++;
                $display("%0t: entries_used mismatch, expected %0d, actual %0d",
                         $time, e.entries_used, got.entries_used);
            end
        endfunction
    endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench for pinned_refcount_key_table_top: clock, reset, request
// driver, response sink with random backpressure, and the final verdict.
// Depends on prc_pkg and prc_tb_pkg.
module tb_top
    import prc_pkg::*;
    import prc_tb_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int PERIOD       = 12;
    localparam int RANDOM_ITEMS = 800;
    localparam int BLOCK_LEN    = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 450;
    localparam int CALM_FIRST   = 150;
    localparam int CALM_LAST    = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_BLEND } traffic_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    table_scoreboard sb = new(DEPTH);
    bit              calm = 1'b0;
    int              cycle_count = 0;
    logic [31:0]     pool_file[8];
    logic [31:0]     pool_frag[8];

    pinned_refcount_key_table_top #(.ENTRIES(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < 19);
    endfunction

    // Hold the beat until the block takes it; called right after a rising edge.
    task automatic send_req(req_t r);
        while (take_gap())
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic issue(op_t op, logic [31:0] fk, logic [31:0] gk, logic pin);
        req_t r;
        r.operation = op;
        r.file_key = fk;
        r.fragment_key = gk;
        r.pin_flag = pin;
        send_req(r);
    endtask

    function automatic req_t random_req(traffic_t mix);
        req_t   r;
        entry_t row;
        int     roll;
        int     k;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  r.operation = roll < 88 ? OP_INSERT : roll < 94 ? OP_TOUCH :
                                     roll < 98 ? OP_DELETE : OP_PURGE;
            MIX_DRAIN: r.operation = roll < 6  ? OP_INSERT : roll < 36 ? OP_TOUCH :
                                     roll < 92 ? OP_DELETE : OP_PURGE;
            default:   r.operation = roll < 40 ? OP_INSERT : roll < 70 ? OP_TOUCH :
                                     roll < 95 ? OP_DELETE : OP_PURGE;
        endcase
        roll = $urandom_range(99);
        if (roll < 60 && sb.rows.size() > 0)
        begin
            row = sb.any_row();
            r.file_key = row.file;
            r.fragment_key = row.fragment;
        end
        else if (roll < 85)
        begin
            k = $urandom_range(7);
            r.file_key = pool_file[k];
            r.fragment_key = pool_frag[k];
        end
        else
        begin
            r.file_key = $urandom;
            r.fragment_key = $urandom;
        end
        r.pin_flag = ($urandom_range(99) < 20);
        return r;
    endfunction

    // Response sink: random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (!held && sb.accepted >= HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    initial
    begin
        traffic_t mix;
        foreach (pool_file[i])
        begin
            pool_file[i] = $urandom;
            pool_frag[i] = $urandom;
        end
        pool_file[0] = '0;
        pool_frag[0] = '1;
        pool_file[1] = '1;
        pool_frag[1] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty table, extreme keys, duplicates, pinning, purge.
        issue(OP_PURGE,  32'h0,         32'h0,         1'b0);
        issue(OP_TOUCH,  32'h0,         32'h0,         1'b0);
        issue(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        issue(OP_INSERT, 32'h0,         32'h0,         1'b0);
        issue(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        issue(OP_INSERT, 32'h0,         32'h0,         1'b1);
        issue(OP_TOUCH,  32'h0,         32'h0,         1'b0);
        issue(OP_TOUCH,  32'h0,         32'h0,         1'b1);
        issue(OP_TOUCH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        // frontmost duplicate is pinned, so the unpinned one behind it stays
        issue(OP_DELETE, 32'h0,         32'h0,         1'b0);
        issue(OP_TOUCH,  32'h0,         32'hFFFF_FFFF, 1'b0);
        issue(OP_TOUCH,  32'hFFFF_FFFF, 32'h0,         1'b0);
        issue(OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
        issue(OP_DELETE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
        issue(OP_DELETE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
        issue(OP_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
        issue(OP_INSERT, 32'h0000_0001, 32'h0000_0002, 1'b0);
        issue(OP_TOUCH,  32'h0000_0001, 32'h0000_0002, 1'b0);
        issue(OP_PURGE,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b1);
        issue(OP_PURGE,  32'h0,         32'h0,         1'b0);
        issue(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        issue(OP_TOUCH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        mix = MIX_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BLOCK_LEN == 0 && n != 0)
                mix = traffic_t'($urandom_range(2));
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            send_req(random_req(mix));
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d insert, %0d touch, %0d delete, %0d purge",
                 sb.accepted, sb.op_seen[OP_INSERT], sb.op_seen[OP_TOUCH],
                 sb.op_seen[OP_DELETE], sb.op_seen[OP_PURGE]);
        $display("Outcomes: %0d done, %0d not found, %0d full, %0d kept pinned",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_PINNED]);
        $display("%0d responses checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/prc_pkg.sv
rtl/core/prc_cell.sv
rtl/core/pinned_refcount_key_table_top.sv
dv/prc_tb_pkg.sv
dv/tb_top.sv
